FILE: sv/bss_pkg.sv
// Types, codes and a helper function shared by the block signal sequencer files.
package bss_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_DISTANCE_THRESHOLD = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROTATOR_DRIVE_POWER = 1'd1;

  localparam logic [7:0] THRESHOLD_RESET = 8'd10;
  localparam logic [7:0] DRIVE_POWER_RESET = 8'd10;

  localparam logic [2:0] COL_BLUE = 3'd2;
  localparam logic [2:0] COL_GREEN = 3'd3;
  localparam logic [2:0] COL_YELLOW = 3'd4;
  localparam logic [2:0] COL_RED = 3'd5;
  localparam logic [2:0] COL_NONE = 3'd0;

  localparam logic ASPECT_STOP = 1'b0;
  localparam logic ASPECT_DEP = 1'b1;

  typedef enum logic [2:0] {
    BLK_INIT,
    BLK_TO_STOP,
    BLK_STOPPED,
    BLK_TO_DEP,
    BLK_DEP
  } blk_mode_t;

  typedef enum logic [2:0] {
    DISP_INIT,
    DISP_WAIT_STOP,
    DISP_STOP,
    DISP_WAIT_DEP,
    DISP_DEP
  } disp_mode_t;

  typedef enum logic [1:0] {
    ROT_INIT,
    ROT_CHECKER_OFF,
    ROT_CHECKER_ON,
    ROT_STOPPED
  } rot_mode_t;

  typedef enum logic [1:0] {
    LED_OFF,
    LED_AMBER,
    LED_RED,
    LED_CLEAR
  } led_t;

  typedef enum logic [1:0] {
    SIG_NONE,
    SIG_STOP,
    SIG_DEP
  } sig_t;

  typedef struct packed {
    logic       switch_pressed;
    logic       checker_pressed;
    logic [7:0] distance;
    logic [2:0] colour;
  } item_t;

  typedef struct packed {
    logic              ready_res;
    logic        [2:0] block_state;
    logic        [2:0] display_state;
    logic        [1:0] panel_state;
    logic signed [7:0] motor_power;
    logic        [1:0] led_colour;
    logic        [1:0] current_signal;
  } res_t;

  typedef struct packed {
    logic       [7:0] distance_threshold;
    logic signed [7:0] rotator_drive_power;
  } cfg_t;

  typedef struct packed {
    logic              started;
    blk_mode_t         blk_mode;
    logic              blk_entry;
    disp_mode_t        disp_mode;
    logic              disp_entry;
    logic              req_aspect;
    logic        [2:0] kept_colour;
    rot_mode_t         rot_mode;
    logic              rot_entry;
    logic              rot_req;
    logic signed [7:0] motor_level;
    led_t              light;
  } st_t;

  function automatic sig_t signal_of(input logic [2:0] colour);
    sig_t s;
    s = SIG_NONE;
    if (colour == COL_RED) begin
      s = SIG_STOP;
    end else if (colour == COL_GREEN) begin
      s = SIG_DEP;
    end
    return s;
  endfunction

endpackage

FILE: sv/bss_fsm.sv
// The three state machines with their state registers and the result of one item.
module bss_fsm
  import bss_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  st_t  st_r;
  st_t  st_nxt;
  sig_t sig_old;
  logic rotated;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.started     <= 1'b0;
      st_r.blk_mode    <= BLK_INIT;
      st_r.blk_entry   <= 1'b1;
      st_r.disp_mode   <= DISP_INIT;
      st_r.disp_entry  <= 1'b1;
      st_r.req_aspect  <= ASPECT_STOP;
      st_r.kept_colour <= COL_NONE;
      st_r.rot_mode    <= ROT_INIT;
      st_r.rot_entry   <= 1'b1;
      st_r.rot_req     <= 1'b0;
      st_r.motor_level <= 8'sd0;
      st_r.light       <= LED_OFF;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    sig_old = signal_of(st_r.kept_colour);
    rotated = (st_r.rot_mode == ROT_STOPPED);
    if (!st_r.started) begin
      if (item.distance > cfg.distance_threshold) begin
        st_nxt.started = 1'b1;
      end
    end else begin
      // Block signal machine.
      st_nxt.blk_entry = 1'b0;
      case (st_r.blk_mode)
        BLK_INIT: begin
          st_nxt.blk_mode  = BLK_TO_STOP;
          st_nxt.blk_entry = 1'b1;
        end
        BLK_TO_STOP: begin
          if (st_r.blk_entry) begin
            st_nxt.req_aspect = ASPECT_STOP;
          end
          if (sig_old == SIG_STOP) begin
            st_nxt.blk_mode  = BLK_STOPPED;
            st_nxt.blk_entry = 1'b1;
          end
        end
        BLK_STOPPED: begin
          if (item.switch_pressed) begin
            st_nxt.blk_mode  = BLK_TO_DEP;
            st_nxt.blk_entry = 1'b1;
          end
        end
        BLK_TO_DEP: begin
          if (st_r.blk_entry) begin
            st_nxt.req_aspect = ASPECT_DEP;
          end
          if (sig_old == SIG_DEP) begin
            st_nxt.blk_mode  = BLK_DEP;
            st_nxt.blk_entry = 1'b1;
          end
        end
        BLK_DEP: begin
          if (item.switch_pressed || (item.distance < cfg.distance_threshold)) begin
            st_nxt.blk_mode  = BLK_TO_STOP;
            st_nxt.blk_entry = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Signal display machine.
      if (item.colour inside {COL_RED, COL_GREEN, COL_BLUE, COL_YELLOW}) begin
        st_nxt.kept_colour = item.colour;
      end
      st_nxt.disp_entry = 1'b0;
      case (st_r.disp_mode)
        DISP_INIT: begin
          if (st_r.disp_entry) begin
            st_nxt.req_aspect = ASPECT_STOP;
          end
          st_nxt.disp_mode  = DISP_WAIT_STOP;
          st_nxt.disp_entry = 1'b1;
        end
        DISP_WAIT_STOP: begin
          if (st_r.disp_entry) begin
            st_nxt.rot_req = 1'b1;
            st_nxt.light   = LED_AMBER;
          end
          if (rotated) begin
            st_nxt.disp_mode  = (st_nxt.kept_colour == COL_RED) ? DISP_STOP : DISP_WAIT_STOP;
            st_nxt.disp_entry = 1'b1;
          end else if (st_nxt.req_aspect == ASPECT_DEP) begin
            st_nxt.disp_mode  = DISP_WAIT_DEP;
            st_nxt.disp_entry = 1'b1;
          end
        end
        DISP_STOP: begin
          if (st_r.disp_entry) begin
            st_nxt.rot_req = 1'b0;
            st_nxt.light   = LED_RED;
          end
          if (st_nxt.req_aspect == ASPECT_DEP) begin
            st_nxt.disp_mode  = DISP_WAIT_DEP;
            st_nxt.disp_entry = 1'b1;
          end
        end
        DISP_WAIT_DEP: begin
          if (st_r.disp_entry) begin
            st_nxt.rot_req = 1'b1;
            st_nxt.light   = LED_AMBER;
          end
          if (rotated) begin
            st_nxt.disp_mode  = (st_nxt.kept_colour == COL_GREEN) ? DISP_DEP : DISP_WAIT_DEP;
            st_nxt.disp_entry = 1'b1;
          end else if (st_nxt.req_aspect == ASPECT_STOP) begin
            st_nxt.disp_mode  = DISP_WAIT_STOP;
            st_nxt.disp_entry = 1'b1;
          end
        end
        DISP_DEP: begin
          if (st_r.disp_entry) begin
            st_nxt.rot_req = 1'b0;
            st_nxt.light   = LED_CLEAR;
          end
          if (st_nxt.req_aspect == ASPECT_STOP) begin
            st_nxt.disp_mode  = DISP_WAIT_STOP;
            st_nxt.disp_entry = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // Panel rotator machine.
      st_nxt.rot_entry = 1'b0;
      case (st_r.rot_mode)
        ROT_INIT: begin
          if (st_r.rot_entry) begin
            st_nxt.rot_req = 1'b0;
          end
          st_nxt.rot_mode  = ROT_CHECKER_OFF;
          st_nxt.rot_entry = 1'b1;
        end
        ROT_CHECKER_OFF: begin
          if (st_r.rot_entry) begin
            st_nxt.rot_req     = 1'b1;
            st_nxt.motor_level = cfg.rotator_drive_power;
          end
          if (item.checker_pressed) begin
            st_nxt.rot_mode  = ROT_CHECKER_ON;
            st_nxt.rot_entry = 1'b1;
          end
        end
        ROT_CHECKER_ON: begin
          if (st_r.rot_entry) begin
            st_nxt.rot_req     = 1'b1;
            st_nxt.motor_level = cfg.rotator_drive_power;
          end
          if (!item.checker_pressed) begin
            st_nxt.rot_mode    = ROT_STOPPED;
            st_nxt.rot_entry   = 1'b1;
            st_nxt.motor_level = 8'sd0;
          end
        end
        ROT_STOPPED: begin
          if (st_r.rot_entry) begin
            st_nxt.rot_req = 1'b0;
          end
          if (st_nxt.rot_req) begin
            st_nxt.rot_mode  = ROT_CHECKER_OFF;
            st_nxt.rot_entry = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.ready_res      = st_nxt.started;
    res.block_state    = st_nxt.blk_mode;
    res.display_state  = st_nxt.disp_mode;
    res.panel_state    = st_nxt.rot_mode;
    res.motor_power    = st_nxt.motor_level;
    res.led_colour     = st_nxt.light;
    res.current_signal = signal_of(st_nxt.kept_colour);
  end

endmodule

FILE: sv/block_signal_sequencer.sv
// Top level of the block signal sequencer: input stage, configuration and result register.
//
//   channel   ports                          role
//   input     in_valid, in_ready, in_data    one tick of sensor samples per item
//   result    out_valid, out_ready, out_data one result item per input item
//   config    cfg_we, cfg_index, cfg_wdata   register writes, taken on any cycle
//
// An item goes from the input register through the combinational machine update to the
// result register; the pipeline takes one item per cycle while the result is not stalled.
// Reset sets all machines to init, the configuration to its defaults and the valid flags
// low; there is no clearing pass. A stalled result holds the result register, and the input
// register still takes one more item before in_ready falls.
module block_signal_sequencer
  import bss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  item_t               in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output res_t                out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t  cfg_r;
  logic  s1_valid_r;
  item_t s1_data_r;
  logic  out_valid_r;
  res_t  out_data_r;
  res_t  res;
  logic  s1_move;
  logic  step;

  assign s1_move  = out_ready || !out_valid_r;
  assign step     = s1_valid_r && s1_move;
  assign in_ready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.distance_threshold  <= THRESHOLD_RESET;
      cfg_r.rotator_drive_power <= DRIVE_POWER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DISTANCE_THRESHOLD:  cfg_r.distance_threshold  <= cfg_wdata;
        CFG_ROTATOR_DRIVE_POWER: cfg_r.rotator_drive_power <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_move) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (step) begin
      out_data_r <= res;
    end
  end

  bss_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (s1_data_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_ready_needs_full_stage: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled while the pipeline can move");

  a_ready_res_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.ready_res) |=> (!out_valid_r || out_data_r.ready_res))
    else $error("ready_res fell after start-up");

  a_idle_motor_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.panel_state == ROT_STOPPED ||
                     out_data_r.panel_state == ROT_INIT)) |-> (out_data_r.motor_power == 8'sd0))
    else $error("motor driven while the panel rotator is not rotating");

endmodule
